// File: hw/rtl/clock_frame_replacement_macros.svh
// Assertion macros used by the checker file.
`ifndef CLOCK_FRAME_REPLACEMENT_MACROS_SVH
`define CLOCK_FRAME_REPLACEMENT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cfr_pkg.sv
// Types and constants of the clock frame replacement block.
`default_nettype none

package cfr_pkg;

  localparam int unsigned REG_W   = 11;   // configuration registers and hand
  localparam int unsigned IDX_W   = 10;   // frame index field
  localparam int unsigned CFG_A_W = 1;    // configuration register index

  localparam logic [REG_W-1:0] FIRST_FRAME_RST = 11'd0;
  localparam logic [REG_W-1:0] FRAME_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_ACCESS = 2'd2,
    MODE_VICTIM = 2'd3
  } mode_e;

  typedef enum logic [CFG_A_W-1:0] {
    REG_FIRST_FRAME = 1'd0,
    REG_FRAME_COUNT = 1'd1
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_READ   = 3'd2,
    ST_EVAL   = 3'd3,
    ST_RESULT = 3'd4
  } state_e;

  // Memory port controls from the sequencer.
  typedef struct packed {
    logic rd_en;
    logic occ_we;
    logic occ_wd;
    logic ref_we;
    logic ref_wd;
    logic data_we;
  } ram_ctl_t;

  // Sequencer status towards the top level.
  typedef struct packed {
    logic             ready;
    logic             load;
    logic             none;
    logic [IDX_W-1:0] frame;
  } sweep_st_t;

endpackage

`default_nettype wire

// File: hw/rtl/clock_frame_replacement.sv
// Clock (second-chance) frame replacement table, top level.
//
// Input channel (in_valid_i / in_stall_o): one word is an event of mode
// insert, delete, mark accessed or victim request. Insert, delete and access
// are single table writes made as they are taken and give no result; a frame
// index at or beyond FRAMES is ignored. A victim request sweeps frames from
// the clock hand, reading each from memory, then testing it and clearing its
// mark if it is passed over, wrapping once to first_frame at the range end.
// The result word appears as the sequencer returns to idle, where the next
// word can be taken; an empty range answers with none_found_o without a
// sweep. Output channel (out_valid_o / out_stall_i): a result sits in an
// output register; the next event is taken while it waits. A finished sweep
// holds its result until that register frees, and the input stays stalled.
// Configuration (cfg_valid_i / cfg_ready_o): index 0 first_frame, index 1
// frame_count; always ready. The user must have them written only while the
// block is idle; the block does not enforce it. Reset: the hand returns to
// zero and a clearing pass over all FRAMES entries wipes the occupied and
// referenced marks; the input stays stalled until it ends. Owner and page
// memories are not cleared; their contents are used only when occupied.
`default_nettype none

module clock_frame_replacement import cfr_pkg::*; #(
  parameter int unsigned FRAMES     = 1024,
  parameter int unsigned OWNER_BITS = 8,
  parameter int unsigned PAGE_BITS  = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // events
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            mode_i,
  input  wire logic [IDX_W-1:0]      frame_index_i,
  input  wire logic [OWNER_BITS-1:0] owner_id_i,
  input  wire logic [PAGE_BITS-1:0]  user_page_i,
  // results
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [IDX_W-1:0]           victim_frame_o,
  output logic [OWNER_BITS-1:0]      victim_owner_o,
  output logic [PAGE_BITS-1:0]       victim_page_o,
  output logic                       none_found_o,
  // configuration
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_A_W-1:0]    cfg_index_i,
  input  wire logic [REG_W-1:0]      cfg_data_i
);

  localparam int unsigned AW     = $clog2(FRAMES);
  localparam int unsigned DATA_W = OWNER_BITS + PAGE_BITS;

  logic [REG_W-1:0] first_frame_q;
  logic [REG_W-1:0] frame_count_q;

  logic              out_valid_q;
  logic [IDX_W-1:0]  victim_frame_q;
  logic [OWNER_BITS-1:0] victim_owner_q;
  logic [PAGE_BITS-1:0]  victim_page_q;
  logic              none_found_q;
  logic              out_free;

  logic [AW-1:0]     addr;
  ram_ctl_t          ctl;
  sweep_st_t         st;
  logic              occ_rd;
  logic              ref_rd;
  logic [DATA_W-1:0] data_rd;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_frame_q <= FIRST_FRAME_RST;
      frame_count_q <= FRAME_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_FIRST_FRAME: first_frame_q <= cfg_data_i;
        REG_FRAME_COUNT: frame_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !st.ready;

  cfr_ctrl #(
    .FRAMES (FRAMES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .mode_i        (mode_i),
    .frame_index_i (frame_index_i),
    .first_frame_i (first_frame_q),
    .frame_count_i (frame_count_q),
    .out_free_i    (out_free),
    .occ_rd_i      (occ_rd),
    .ref_rd_i      (ref_rd),
    .addr_o        (addr),
    .ctl_o         (ctl),
    .st_o          (st)
  );

  // occupied marks
  cfr_ram #(
    .WIDTH (1),
    .DEPTH (FRAMES)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.occ_we),
    .waddr_i (addr),
    .wdata_i (ctl.occ_wd),
    .re_i    (ctl.rd_en),
    .raddr_i (addr),
    .rdata_o (occ_rd)
  );

  // referenced marks
  cfr_ram #(
    .WIDTH (1),
    .DEPTH (FRAMES)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.ref_we),
    .waddr_i (addr),
    .wdata_i (ctl.ref_wd),
    .re_i    (ctl.rd_en),
    .raddr_i (addr),
    .rdata_o (ref_rd)
  );

  // owner and page, packed as {owner, page}
  cfr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FRAMES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.data_we),
    .waddr_i (addr),
    .wdata_i ({owner_id_i, user_page_i}),
    .re_i    (ctl.rd_en),
    .raddr_i (addr),
    .rdata_o (data_rd)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // unowned frame or empty range report zero owner and page
  always_ff @(posedge clk_i) begin
    if (st.load) begin
      none_found_q   <= st.none;
      victim_frame_q <= st.none ? '0 : st.frame;
      victim_owner_q <= (st.none || !occ_rd) ? '0 : data_rd[DATA_W-1:PAGE_BITS];
      victim_page_q  <= (st.none || !occ_rd) ? '0 : data_rd[PAGE_BITS-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign victim_frame_o = victim_frame_q;
  assign victim_owner_o = victim_owner_q;
  assign victim_page_o  = victim_page_q;
  assign none_found_o   = none_found_q;

endmodule

`default_nettype wire

// File: hw/rtl/cfr_ram.sv
// Generic RAM: one write port, one read port, registered read data.
`default_nettype none

module cfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/cfr_ctrl.sv
// Sequencer: mark clearing pass, table updates and the clock sweep.
`default_nettype none

module cfr_ctrl import cfr_pkg::*; #(
  parameter int unsigned FRAMES = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [1:0]                  mode_i,
  input  wire logic [IDX_W-1:0]            frame_index_i,
  input  wire logic [REG_W-1:0]            first_frame_i,
  input  wire logic [REG_W-1:0]            frame_count_i,
  input  wire logic                        out_free_i,
  input  wire logic                        occ_rd_i,
  input  wire logic                        ref_rd_i,
  output logic      [$clog2(FRAMES)-1:0]   addr_o,
  output ram_ctl_t                         ctl_o,
  output sweep_st_t                        st_o
);

  localparam int unsigned AW = $clog2(FRAMES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(FRAMES - 1);

  state_e           state_q, state_d;
  logic [REG_W-1:0] cur_q, cur_d;
  logic [REG_W-1:0] hand_q, hand_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             none_q, none_d;

  logic [REG_W-1:0] stop;
  logic [REG_W-1:0] cur_inc;
  logic             accept;
  logic             idx_ok;
  logic             empty;
  logic             hit;

  // end of the eligible range, clamped to the table
  always_comb begin
    if (32'(frame_count_i) < FRAMES) begin
      stop = frame_count_i;
    end else begin
      stop = REG_W'(FRAMES);
    end
  end

  assign cur_inc = cur_q + REG_W'(1);
  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign idx_ok  = 32'(frame_index_i) < FRAMES;
  assign empty   = first_frame_i >= stop;
  assign hit     = !occ_rd_i || !ref_rd_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (mode_e'(mode_i) == MODE_VICTIM)) begin
          state_d = empty ? ST_RESULT : ST_READ;
        end
      end
      ST_READ:   state_d = ST_EVAL;
      ST_EVAL:   state_d = hit ? ST_RESULT : ST_READ;
      ST_RESULT: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ctl_o    = '0;
    addr_o   = AW'(cur_q);
    cur_d    = cur_q;
    hand_d   = hand_q;
    clr_d    = clr_q;
    none_d   = none_q;
    st_o.ready = 1'b0;
    st_o.load  = 1'b0;
    st_o.none  = none_q;
    st_o.frame = cur_q[IDX_W-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        addr_o       = clr_q;
        ctl_o.occ_we = 1'b1;
        ctl_o.ref_we = 1'b1;
        clr_d        = clr_q + AW'(1);
      end
      ST_IDLE: begin
        st_o.ready = 1'b1;
        addr_o     = AW'(frame_index_i);
        if (accept) begin
          unique case (mode_e'(mode_i))
            MODE_INSERT: begin
              ctl_o.occ_we  = idx_ok;
              ctl_o.occ_wd  = 1'b1;
              ctl_o.ref_we  = idx_ok;
              ctl_o.data_we = idx_ok;
            end
            MODE_DELETE: begin
              ctl_o.occ_we = idx_ok;
              ctl_o.ref_we = idx_ok;
            end
            MODE_ACCESS: begin
              ctl_o.ref_we = idx_ok;
              ctl_o.ref_wd = 1'b1;
            end
            MODE_VICTIM: begin
              none_d = empty;
              if ((hand_q < first_frame_i) || (hand_q >= stop)) begin
                cur_d = first_frame_i;
              end else begin
                cur_d = hand_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        ctl_o.rd_en = 1'b1;
      end
      ST_EVAL: begin
        if (hit) begin
          hand_d = cur_inc;
        end else begin
          // second chance: drop the mark and move on
          ctl_o.ref_we = 1'b1;
          cur_d        = (cur_inc == stop) ? first_frame_i : cur_inc;
        end
      end
      ST_RESULT: begin
        st_o.load = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cur_q   <= '0;
      hand_q  <= '0;
      clr_q   <= '0;
      none_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      hand_q  <= hand_d;
      clr_q   <= clr_d;
      none_q  <= none_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cfr_checker.sv
// Port-level checker for the clock frame replacement block, with its bind.
`default_nettype none
`include "clock_frame_replacement_macros.svh"

module cfr_checker import cfr_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic [1:0]       mode_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [IDX_W-1:0] victim_frame_o,
  input wire logic             none_found_o
);

  `CFR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `CFR_ASSERT_NXT(a_frame_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(victim_frame_o), "stalled result changed")
  `CFR_ASSERT_IMP(a_none_zero, clk_i, rst_ni, out_valid_o && none_found_o, victim_frame_o == '0, "empty range with non-zero frame")
  `CFR_ASSERT_NXT(a_victim_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (mode_i == MODE_VICTIM), in_stall_o, "victim request did not hold the input")

endmodule

bind clock_frame_replacement cfr_checker u_cfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .mode_i         (mode_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .victim_frame_o (victim_frame_o),
  .none_found_o   (none_found_o)
);

`default_nettype wire

// File: tb/clock_frame_replacement_test.sv
// Self-checking testbench for the clock frame replacement block.
module clock_frame_replacement_test;
  import cfr_pkg::*;

  localparam int unsigned FRAME_TOTAL = 1024;
  localparam int unsigned OWNER_W     = 8;
  localparam int unsigned PAGE_W      = 20;
  localparam int unsigned WORD_TARGET = 1800;
  // Slowest plausible run: the clearing pass, then mostly short sweeps over
  // small ranges, a few full-range ones, receiver stalls and one long hold-off.
  // CYCLE_LIMIT is several times that.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned LONG_HOLD   = 400;   // cycles of the one long hold-off
  localparam int unsigned SETTLE      = 16;    // table writes finish well within this

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [OWNER_W-1:0] owner_t;
  typedef logic [PAGE_W-1:0]  page_t;

  typedef struct packed {
    idx_t   frame;
    owner_t owner;
    page_t  page;
    logic   none;
  } victim_t;

  // Mirror of the frame table plus the queue of victims still to come out.
  class victim_scoreboard;
    owner_t      owner_tab [FRAME_TOTAL];
    page_t       page_tab  [FRAME_TOTAL];
    bit          occupied  [FRAME_TOTAL];
    bit          referenced[FRAME_TOTAL];
    int unsigned hand;
    int unsigned first_frame;
    int unsigned frame_count;
    victim_t     victim_q[$];
    int unsigned words_taken;
    int unsigned victims_checked;
    int unsigned empty_answers;
    int unsigned errors;

    function new();
      hand        = 0;
      first_frame = FIRST_FRAME_RST;
      frame_count = FRAME_COUNT_RST;
    endfunction

    function void set_reg(reg_e r, int unsigned v);
      if (r == REG_FIRST_FRAME) first_frame = v;
      else frame_count = v;
    endfunction

    // Apply one accepted word; a victim request queues its answer.
    function void note_word(mode_e m, idx_t idx, owner_t own, page_t pg);
      victim_t     v;
      int unsigned stop;
      int unsigned from;
      int unsigned i;
      int          pass;
      int          hit;
      v   = '0;
      hit = -1;
      words_taken++;
      case (m)
        MODE_INSERT: begin
          owner_tab[idx]  = own;
          page_tab[idx]   = pg;
          occupied[idx]   = 1'b1;
          referenced[idx] = 1'b0;
        end
        MODE_DELETE: begin
          owner_tab[idx]  = '0;
          page_tab[idx]   = '0;
          occupied[idx]   = 1'b0;
          referenced[idx] = 1'b0;
        end
        MODE_ACCESS: referenced[idx] = 1'b1;
        default: begin
          stop = (frame_count < FRAME_TOTAL) ? frame_count : FRAME_TOTAL;
          if (first_frame >= stop) begin
            v.none = 1'b1;
          end else begin
            from = (hand < first_frame || hand >= stop) ? first_frame : hand;
            // second chance: the first pass clears marks, so the wrap always hits
            for (pass = 0; pass < 2 && hit < 0; pass++) begin
              for (i = (pass == 0) ? from : first_frame; i < stop && hit < 0; i++) begin
                if (!occupied[i] || !referenced[i]) hit = i;
                else referenced[i] = 1'b0;
              end
            end
            hand    = hit + 1;
            v.frame = idx_t'(hit);
            if (occupied[hit]) begin
              v.owner = owner_tab[hit];
              v.page  = page_tab[hit];
            end
          end
          victim_q.push_back(v);
        end
      endcase
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(victim_t got);
      victim_t want;
      if (victim_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected victim, expected nothing, got frame %0h owner %0h page %0h none %0b",
                 $time, got.frame, got.owner, got.page, got.none);
        return;
      end
      want = victim_q.pop_front();
      victims_checked++;
      if (want.none) empty_answers++;
      compare("victim_frame", want.frame, got.frame);
      compare("victim_owner", want.owner, got.owner);
      compare("victim_page",  want.page,  got.page);
      compare("none_found",   want.none,  got.none);
    endfunction
  endclass

  victim_scoreboard sb = new;

  logic          clk_i          = 1'b0;
  logic          rst_ni         = 1'b0;
  logic          in_valid_i     = 1'b0;
  logic          in_stall_o;
  logic [1:0]    mode_i         = '0;
  idx_t          frame_index_i  = '0;
  owner_t        owner_id_i     = '0;
  page_t         user_page_i    = '0;
  logic          out_valid_o;
  logic          out_stall_i    = 1'b0;
  idx_t          victim_frame_o;
  owner_t        victim_owner_o;
  page_t         victim_page_o;
  logic          none_found_o;
  logic          cfg_valid_i    = 1'b0;
  logic          cfg_ready_o;
  logic [CFG_A_W-1:0] cfg_index_i = '0;
  logic [REG_W-1:0]   cfg_data_i  = '0;

  bit            long_hold_req;   // raised by the sender side, served by the receiver
  int unsigned   cycles;
  int unsigned   range_settings;

  clock_frame_replacement #(
    .FRAMES    (FRAME_TOTAL),
    .OWNER_BITS(OWNER_W),
    .PAGE_BITS (PAGE_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .frame_index_i (frame_index_i),
    .owner_id_i    (owner_id_i),
    .user_page_i   (user_page_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .victim_frame_o(victim_frame_o),
    .victim_owner_o(victim_owner_o),
    .victim_page_o (victim_page_o),
    .none_found_o  (none_found_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d victims outstanding", $time, sb.victim_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: sampled at the rising edge, before the block's own updates land.
  always @(posedge clk_i) begin
    victim_t got;
    got = {victim_frame_o, victim_owner_o, victim_page_o, none_found_o};
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(got);
  end

  // Receiver stall pattern. It changes style every so often (never stall,
  // light, heavy), and serves the one long hold-off when asked; the hold-off is
  // counted here so the sender keeps pushing words meanwhile.
  initial begin
    int unsigned hold_left;
    int unsigned span;
    int unsigned stall_pct;
    hold_left = 0;
    span      = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        out_stall_i   <= 1'b1;
      end else begin
        if (span == 0) begin
          span = $urandom_range(20, 200);
          case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            default: stall_pct = 75;
          endcase
        end
        span--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // --- sender tasks; each one is entered and left at a falling edge ---

  task automatic offer_word(mode_e m, idx_t idx, owner_t own, page_t pg);
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    frame_index_i <= idx;
    owner_id_i    <= own;
    user_page_i   <= pg;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(m, idx, own, pg);
    @(negedge clk_i);
  endtask

  task automatic idle_for(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Sender pause: every victim back, then time for trailing table writes.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.victim_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e r, int unsigned v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= REG_W'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(r, v);
    @(negedge clk_i);
  endtask

  // Registers are only touched with the block idle.
  task automatic retarget_range(int unsigned first, int unsigned count);
    wait_drained();
    write_reg(REG_FIRST_FRAME, first);
    write_reg(REG_FRAME_COUNT, count);
    cfg_valid_i <= 1'b0;
    range_settings++;
  endtask

  // One random word; most hit frames inside the current range so sweeps meet
  // occupied, referenced frames, the rest land anywhere.
  task automatic random_word(int unsigned first, int unsigned count, int unsigned victim_pct);
    mode_e       m;
    idx_t        idx;
    int unsigned r;
    int unsigned top;
    r   = $urandom_range(0, 99);
    top = (count < FRAME_TOTAL) ? count : FRAME_TOTAL;
    if (r < victim_pct)                        m = MODE_VICTIM;
    else if (r < victim_pct + (100 - victim_pct) / 2) m = MODE_INSERT;
    else if ($urandom_range(0, 3) != 0)        m = MODE_ACCESS;
    else                                       m = MODE_DELETE;
    if (first < top && $urandom_range(0, 99) < 85) idx = idx_t'($urandom_range(first, top - 1));
    else idx = idx_t'($urandom_range(0, FRAME_TOTAL - 1));
    offer_word(m, idx, owner_t'($urandom), page_t'($urandom));
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned first;
    int unsigned count;
    int unsigned victim_pct;

    // Reset once; the block then runs its clearing pass with the input stalled.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, reset range first (whole table).
    offer_word(MODE_VICTIM, 10'd0, 8'd0, 20'd0);          // empty table: frame 0, unowned
    offer_word(MODE_INSERT, 10'd1, 8'hFF, 20'hFFFFF);
    offer_word(MODE_INSERT, 10'd2, 8'h00, 20'h00000);
    offer_word(MODE_ACCESS, 10'd1, 8'h00, 20'h00000);
    offer_word(MODE_VICTIM, 10'd0, 8'h00, 20'h00000);     // frame 1 gets its second chance
    offer_word(MODE_INSERT, 10'd1023, 8'hA5, 20'h5A5A5);
    offer_word(MODE_ACCESS, 10'd1023, 8'h00, 20'h00000);
    offer_word(MODE_ACCESS, 10'd3, 8'h00, 20'h00000);     // access to an unowned frame
    offer_word(MODE_VICTIM, 10'd0, 8'h00, 20'h00000);     // unowned frame taken regardless
    offer_word(MODE_DELETE, 10'd2, 8'h00, 20'h00000);
    offer_word(MODE_VICTIM, 10'd0, 8'h00, 20'h00000);

    // Top of the table, hand below the range, every frame referenced: full wrap.
    retarget_range(1021, 1024);
    offer_word(MODE_INSERT, 10'd1021, 8'h3C, 20'hC3C3C);
    offer_word(MODE_INSERT, 10'd1022, 8'h81, 20'h18181);
    offer_word(MODE_ACCESS, 10'd1021, 8'h00, 20'h00000);
    offer_word(MODE_ACCESS, 10'd1022, 8'h00, 20'h00000);
    offer_word(MODE_VICTIM, 10'd0, 8'h00, 20'h00000);
    offer_word(MODE_VICTIM, 10'd0, 8'h00, 20'h00000);

    // Empty ranges: first at the very top, zero count, first above count.
    retarget_range(1024, 1024);
    offer_word(MODE_VICTIM, 10'd0, 8'h00, 20'h00000);
    retarget_range(0, 0);
    offer_word(MODE_VICTIM, 10'd0, 8'h00, 20'h00000);
    retarget_range(7, 3);
    offer_word(MODE_DELETE, 10'd1023, 8'h00, 20'h00000);
    offer_word(MODE_VICTIM, 10'd0, 8'h00, 20'h00000);
    retarget_range(0, 1024);
    offer_word(MODE_VICTIM, 10'd0, 8'h00, 20'h00000);

    // Random phases, each under its own range. Mostly narrow windows so the
    // hand laps often; a few whole-table, edge and empty ranges.
    phase_no = 0;
    while (sb.words_taken < WORD_TARGET) begin
      case ($urandom_range(0, 19))
        0: begin
          first = 0;
          count = FRAME_TOTAL;
        end
        1: begin
          first = $urandom_range(0, FRAME_TOTAL);
          count = $urandom_range(0, first);
        end
        2: begin
          first = $urandom_range(FRAME_TOTAL - 24, FRAME_TOTAL - 1);
          count = FRAME_TOTAL;
        end
        3: begin
          first = 0;
          count = $urandom_range(1, 16);
        end
        default: begin
          first = $urandom_range(0, FRAME_TOTAL - 4);
          count = first + $urandom_range(1, 24);
          if (count > FRAME_TOTAL) count = FRAME_TOTAL;
        end
      endcase
      retarget_range(first, count);

      victim_pct = 25;
      if (phase_no == 2) begin
        // receiver goes quiet while victim requests pile up behind it
        long_hold_req = 1'b1;
        victim_pct    = 60;
      end

      burst_left = 0;
      repeat ($urandom_range(30, 90)) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap != 0) idle_for(gap);
          burst_left = $urandom_range(1, 24);
        end
        random_word(first, count, victim_pct);
        burst_left--;
      end
      phase_no++;
    end

    wait_drained();
    if (sb.victim_q.size() != 0) sb.errors++;

    $display("%0d words taken over %0d range settings; %0d victims checked, %0d on an empty range",
             sb.words_taken, range_settings, sb.victims_checked, sb.empty_answers);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: clock_frame_replacement.f
+incdir+hw/rtl
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_ram.sv
hw/rtl/cfr_ctrl.sv
hw/rtl/clock_frame_replacement.sv
hw/rtl/cfr_checker.sv
tb/clock_frame_replacement_test.sv
